// ===== hdl/crpf_pkg.sv =====
// Shared constants, codes and types of the Catmull-Rom path follower.
package crpf_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 32;
    localparam int PT_AW      = $clog2(MAX_POINTS);
    localparam int PT_W       = 3 * COORD_BITS;
    localparam int CNT_W      = 7;
    localparam int TICK_W     = 16;
    localparam int FRAC_W     = 16;
    localparam int U_W        = FRAC_W + 1;
    localparam int PROG_W     = FRAC_W + 1;
    localparam int DEN_W      = CNT_W + TICK_W;
    localparam int DIV_W      = DEN_W + 1 + FRAC_W;
    localparam int DIV_CW     = $clog2(DIV_W + 1);
    localparam int COEF_W     = COORD_BITS + 4;
    localparam int PROD_W     = COEF_W + U_W + 1;
    localparam int ACC_W      = COORD_BITS + 8;

    localparam int S_TDATA_W  = 104;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 120;
    localparam int CFG_AW     = 2;
    localparam int CFG_DW     = 16;

    localparam logic [PROG_W-1:0] PROG_ONE = PROG_W'(1 << FRAC_W);

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_POINT_COUNT   = 2'd0;
    localparam logic [CFG_AW-1:0] REG_LOOP_MODE     = 2'd1;
    localparam logic [CFG_AW-1:0] REG_SEGMENT_TICKS = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVP,
        ST_STEP,
        ST_DIVU,
        ST_READ,
        ST_CUBIC,
        ST_POS,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        C_IDLE,
        C_T2,
        C_T3,
        C_T3W,
        C_COEF,
        C_MB,
        C_MC,
        C_MD,
        C_ACC,
        C_OUT
    } cub_state_t;

    // Status of a multi-cycle unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ===== hdl/crpf_ram.sv =====
// Generic single-port-write, registered-read RAM.
module crpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/crpf_div.sv =====
// Restoring divider, one quotient bit per cycle.
module crpf_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [crpf_pkg::DIV_W-1:0]     dividend,
    input  logic [crpf_pkg::DEN_W-1:0]     divisor,
    output crpf_pkg::unit_stat_t           stat,
    output logic [crpf_pkg::DIV_W-1:0]     quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [crpf_pkg::DIV_CW-1:0]   cnt_reg;
    logic [crpf_pkg::DIV_W-1:0]    q_reg;
    logic [crpf_pkg::DEN_W-1:0]    rem_reg;
    logic [crpf_pkg::DEN_W-1:0]    den_reg;

    logic [crpf_pkg::DEN_W:0]      rem_sh;
    logic [crpf_pkg::DEN_W+1:0]    diff;
    logic                          ge;

    // Trial subtract of the shifted remainder
    always_comb begin
        rem_sh = {rem_reg, q_reg[crpf_pkg::DIV_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, den_reg};
        ge     = ~diff[crpf_pkg::DEN_W+1];
    end

    // Control: count the quotient bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= crpf_pkg::DIV_CW'(crpf_pkg::DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == crpf_pkg::DIV_CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift the dividend out and the quotient in
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[crpf_pkg::DIV_W-2:0], ge};
            rem_reg <= ge ? diff[crpf_pkg::DEN_W-1:0] : rem_sh[crpf_pkg::DEN_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule

// ===== hdl/crpf_cubic.sv =====
// Catmull-Rom cubic evaluation, one shared multiplier, one axis at a time.
module crpf_cubic (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [crpf_pkg::PT_W-1:0]     pts [4],
    input  logic [crpf_pkg::U_W-1:0]      u,
    output crpf_pkg::unit_stat_t          stat,
    output logic [crpf_pkg::PT_W-1:0]     pos
);

    localparam int CB  = crpf_pkg::COORD_BITS;
    localparam int CW  = crpf_pkg::COEF_W;
    localparam int UW  = crpf_pkg::U_W;
    localparam int PW  = crpf_pkg::PROD_W;
    localparam int AW  = crpf_pkg::ACC_W;
    localparam int FW  = crpf_pkg::FRAC_W;

    localparam logic signed [AW-1:0] POS_MAX = {{(AW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [AW-1:0] POS_MIN = ~POS_MAX;

    crpf_pkg::cub_state_t state_reg, state_next;
    logic [1:0]                axis_reg;
    logic                      done_reg;
    logic [UW-1:0]             u_reg;
    logic [UW-1:0]             t2_reg;
    logic [UW-1:0]             t3_reg;
    logic signed [CW-1:0]      a_reg, b_reg, c_reg, d_reg;
    logic signed [PW-1:0]      prod_reg;
    logic signed [AW-1:0]      acc_reg;
    logic [crpf_pkg::PT_W-1:0] pos_reg;

    logic signed [CW-1:0]      pe [4];
    logic signed [CW-1:0]      a_c, b_c, c_c, d_c, diff12;
    logic signed [CW-1:0]      mul_a;
    logic [UW-1:0]             mul_w;
    logic signed [PW-1:0]      product;
    logic signed [PW-FW-1:0]   scl;
    logic signed [AW-1:0]      half;
    logic signed [AW-1:0]      half_sat;

    // Coefficients of the selected axis
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            pe[j] = CW'($signed(pts[j][axis_reg*CB +: CB]));
        end
        diff12 = pe[1] - pe[2];
        a_c    = pe[1] <<< 1;
        b_c    = pe[2] - pe[0];
        c_c    = (pe[0] <<< 1) - ((pe[1] <<< 2) + pe[1]) + (pe[2] <<< 2) - pe[3];
        d_c    = pe[3] - pe[0] + (diff12 <<< 1) + diff12;
    end

    // Shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_w = '0;
        case (state_reg)
            crpf_pkg::C_T2: begin
                mul_a = {{(CW-UW){1'b0}}, u_reg};
                mul_w = u_reg;
            end
            crpf_pkg::C_T3: begin
                mul_a = {{(CW-UW){1'b0}}, prod_reg[FW +: UW]};
                mul_w = u_reg;
            end
            crpf_pkg::C_MB: begin
                mul_a = b_reg;
                mul_w = u_reg;
            end
            crpf_pkg::C_MC: begin
                mul_a = c_reg;
                mul_w = t2_reg;
            end
            crpf_pkg::C_MD: begin
                mul_a = d_reg;
                mul_w = t3_reg;
            end
            default: begin
                mul_a = '0;
                mul_w = '0;
            end
        endcase
        product = mul_a * $signed({1'b0, mul_w});
        scl     = prod_reg[PW-1:FW];
        half    = acc_reg >>> 1;
        if (half > POS_MAX) begin
            half_sat = POS_MAX;
        end else if (half < POS_MIN) begin
            half_sat = POS_MIN;
        end else begin
            half_sat = half;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            crpf_pkg::C_IDLE: if (start) state_next = crpf_pkg::C_T2;
            crpf_pkg::C_T2:   state_next = crpf_pkg::C_T3;
            crpf_pkg::C_T3:   state_next = crpf_pkg::C_T3W;
            crpf_pkg::C_T3W:  state_next = crpf_pkg::C_COEF;
            crpf_pkg::C_COEF: state_next = crpf_pkg::C_MB;
            crpf_pkg::C_MB:   state_next = crpf_pkg::C_MC;
            crpf_pkg::C_MC:   state_next = crpf_pkg::C_MD;
            crpf_pkg::C_MD:   state_next = crpf_pkg::C_ACC;
            crpf_pkg::C_ACC:  state_next = crpf_pkg::C_OUT;
            crpf_pkg::C_OUT: begin
                state_next = (axis_reg == 2'd2) ? crpf_pkg::C_IDLE : crpf_pkg::C_COEF;
            end
            default: state_next = crpf_pkg::C_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= crpf_pkg::C_IDLE;
            axis_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (state_reg == crpf_pkg::C_IDLE) begin
                axis_reg <= '0;
            end else if (state_reg == crpf_pkg::C_OUT) begin
                axis_reg <= axis_reg + 1'b1;
                if (axis_reg == 2'd2) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: powers of u, coefficients, multiply-accumulate
    always_ff @(posedge aclk) begin
        prod_reg <= product;
        case (state_reg)
            crpf_pkg::C_IDLE: if (start) u_reg <= u;
            crpf_pkg::C_T3:   t2_reg <= prod_reg[FW +: UW];
            crpf_pkg::C_T3W:  t3_reg <= prod_reg[FW +: UW];
            crpf_pkg::C_COEF: begin
                a_reg <= a_c;
                b_reg <= b_c;
                c_reg <= c_c;
                d_reg <= d_c;
            end
            crpf_pkg::C_MB:   acc_reg <= AW'(a_reg);
            crpf_pkg::C_MC:   acc_reg <= acc_reg + AW'(scl);
            crpf_pkg::C_MD:   acc_reg <= acc_reg + AW'(scl);
            crpf_pkg::C_ACC:  acc_reg <= acc_reg + AW'(scl);
            crpf_pkg::C_OUT:  pos_reg[axis_reg*CB +: CB] <= half_sat[CB-1:0];
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign stat.busy = (state_reg != crpf_pkg::C_IDLE);
    assign stat.done = done_reg;
    assign pos       = pos_reg;

endmodule

// ===== hdl/catmull_rom_path_follower.sv =====
// Top level of the Catmull-Rom path follower: sequencer, state and output register.
// Usage:
//   s_ channel carries one command per transfer: s_tuser = command; s_tdata holds
//   point_index, coord_x, coord_y, coord_z. A load writes one control point and
//   gives no result. A start or a tick gives exactly one result on the m_ channel:
//   pos_x, pos_y, pos_z (Q16.16), progress (Q1.16), moving, config_error.
//   Configuration registers (point_count, loop_mode, segment_ticks) are written
//   through cfg_we/cfg_addr/cfg_wdata while the block is idle.
// Sequence:
//   A start reads one point (none when the loop is too short) and then runs the
//   progress division. A moving tick that stays on the path runs two 40-step
//   divisions on the shared divider (progress, then curve parameter), four
//   point-memory reads and the three-axis cubic on one shared multiplier.
//   One command is worked on at a time; s_tready is high while the sequencer waits.
// Reset:
//   aresetn (synchronous, active low) clears the follower to inactive at the
//   origin and restores the configuration defaults. The point memory is not cleared.
// Stall:
//   A result waits in the output register until taken; the next command is still
//   accepted, and its result waits until the register is free.
module catmull_rom_path_follower (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: point_index[5:0], coord_x[37:6], coord_y[69:38], coord_z[101:70]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [crpf_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: command[1:0]
    input  logic [crpf_pkg::S_TUSER_W-1:0]    s_tuser,
    // m_tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64], progress[112:96],
    //          moving[113], config_error[114]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [crpf_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_we,
    input  logic [crpf_pkg::CFG_AW-1:0]       cfg_addr,
    input  logic [crpf_pkg::CFG_DW-1:0]       cfg_wdata
);

    localparam int CW = crpf_pkg::CNT_W;
    localparam int TW = crpf_pkg::TICK_W;
    localparam int AW = crpf_pkg::PT_AW;
    localparam int PW = crpf_pkg::PT_W;
    localparam int DW = crpf_pkg::DEN_W;

    // Configuration
    logic [CW-1:0] pc_reg;
    logic          loop_reg;
    logic [TW-1:0] ticks_reg;

    // Follower state and sequencer
    crpf_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    seg_reg, seg_next;
    logic [TW-1:0]    el_reg, el_next;
    logic             active_reg, active_next;
    logic [PW-1:0]    cur_pos_reg, cur_pos_next;
    logic [crpf_pkg::PROG_W-1:0] prog_reg, prog_next;
    logic [crpf_pkg::U_W-1:0]    u_reg, u_next;
    logic [AW-1:0]    idx_reg [4];
    logic [AW-1:0]    idx_next [4];
    logic [PW-1:0]    pt_reg [4];
    logic [PW-1:0]    pt_next [4];
    logic             end_reg, end_next;
    logic             run_reg, run_next;
    logic             sent_reg, sent_next;
    logic [2:0]       rd_cnt_reg, rd_cnt_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [crpf_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Derived values
    logic             accept;
    crpf_pkg::cmd_t   cmd;
    logic [CW-1:0]    n_eff, n_m1, n_m2, s_cnt;
    logic [TW-1:0]    t_eff;
    logic             loop_err;
    logic [TW-1:0]    el_inc;
    logic             tick_wrap;
    logic [DW-1:0]    seg_t;
    logic [DW:0]      prog_base;
    logic [CW:0]      s0, w0, w2, w3;

    // Unit connections
    logic                         ram_we;
    logic [AW-1:0]                ram_raddr;
    logic [PW-1:0]                ram_rdata;
    logic                         div_start;
    logic [crpf_pkg::DIV_W-1:0]   div_dividend;
    logic [DW-1:0]                div_divisor;
    crpf_pkg::unit_stat_t         div_stat;
    logic [crpf_pkg::DIV_W-1:0]   div_q;
    logic                         cub_start;
    crpf_pkg::unit_stat_t         cub_stat;
    logic [PW-1:0]                cub_pos;

    assign s_tready = (state_reg == crpf_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cmd      = crpf_pkg::cmd_t'(s_tuser);
    assign ram_we   = accept && (cmd == crpf_pkg::CMD_LOAD);

    // Clamped counts and error flag
    always_comb begin
        if (pc_reg < CW'(2)) begin
            n_eff = CW'(2);
        end else if (pc_reg > CW'(crpf_pkg::MAX_POINTS)) begin
            n_eff = CW'(crpf_pkg::MAX_POINTS);
        end else begin
            n_eff = pc_reg;
        end
        n_m1     = n_eff - 1'b1;
        n_m2     = n_eff - CW'(2);
        s_cnt    = loop_reg ? n_eff : n_m1;
        t_eff    = (ticks_reg == '0) ? TW'(1) : ticks_reg;
        loop_err = loop_reg && (n_eff < CW'(3));
        el_inc   = el_reg + 1'b1;
        tick_wrap = (el_inc >= t_eff);
        seg_t     = DW'(seg_reg) * DW'(t_eff);
        prog_base = {1'b0, seg_t} + (DW+1)'(el_reg);
    end

    // Divider operands: curve parameter or progress
    always_comb begin
        if (state_reg == crpf_pkg::ST_DIVU) begin
            div_dividend = crpf_pkg::DIV_W'({el_reg, {crpf_pkg::FRAC_W{1'b0}}});
            div_divisor  = DW'(t_eff);
        end else begin
            div_dividend = {prog_base, {crpf_pkg::FRAC_W{1'b0}}};
            div_divisor  = DW'(s_cnt) * DW'(t_eff);
        end
    end

    // Loop-mode neighbor indexes with wrap
    always_comb begin
        s0 = (seg_reg > n_m1) ? '0 : {1'b0, seg_reg};
        w0 = s0 + {1'b0, n_m1};
        if (w0 >= {1'b0, n_eff}) w0 = w0 - {1'b0, n_eff};
        w2 = s0 + (CW+1)'(1);
        if (w2 >= {1'b0, n_eff}) w2 = w2 - {1'b0, n_eff};
        w3 = s0 + (CW+1)'(2);
        if (w3 >= {1'b0, n_eff}) w3 = w3 - {1'b0, n_eff};
    end

    // Sequencer: next state and register updates
    always_comb begin
        state_next    = state_reg;
        seg_next      = seg_reg;
        el_next       = el_reg;
        active_next   = active_reg;
        cur_pos_next  = cur_pos_reg;
        prog_next     = prog_reg;
        u_next        = u_reg;
        idx_next      = idx_reg;
        pt_next       = pt_reg;
        end_next      = end_reg;
        run_next      = run_reg;
        sent_next     = sent_reg;
        rd_cnt_next   = rd_cnt_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ram_raddr     = idx_reg[0];
        div_start     = 1'b0;
        cub_start     = 1'b0;

        case (state_reg)
            crpf_pkg::ST_IDLE: begin
                if (accept) begin
                    case (cmd)
                        crpf_pkg::CMD_START: begin
                            end_next = 1'b0;
                            run_next = 1'b0;
                            if (loop_err) begin
                                state_next = crpf_pkg::ST_DIVP;
                            end else begin
                                seg_next    = '0;
                                el_next     = '0;
                                active_next = 1'b1;
                                idx_next[0] = '0;
                                rd_cnt_next = '0;
                                state_next  = crpf_pkg::ST_POS;
                            end
                        end
                        crpf_pkg::CMD_TICK: begin
                            end_next   = 1'b0;
                            run_next   = 1'b0;
                            state_next = crpf_pkg::ST_DIVP;
                            if (active_reg && loop_err) begin
                                active_next = 1'b0;
                            end else if (active_reg) begin
                                run_next = 1'b1;
                                el_next  = tick_wrap ? '0 : el_inc;
                                seg_next = tick_wrap ? seg_reg + 1'b1 : seg_reg;
                            end
                        end
                        default: begin
                            state_next = crpf_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            crpf_pkg::ST_DIVP: begin
                if (!sent_reg) begin
                    div_start = 1'b1;
                    sent_next = 1'b1;
                end else if (div_stat.done) begin
                    sent_next  = 1'b0;
                    prog_next  = (div_q > crpf_pkg::DIV_W'(crpf_pkg::PROG_ONE)) ?
                                 crpf_pkg::PROG_ONE : div_q[crpf_pkg::PROG_W-1:0];
                    state_next = run_reg ? crpf_pkg::ST_STEP : crpf_pkg::ST_EMIT;
                end
            end
            crpf_pkg::ST_STEP: begin
                rd_cnt_next = '0;
                if (!loop_reg) begin
                    if (seg_reg > n_m2) begin
                        active_next = 1'b0;
                        end_next    = 1'b1;
                        idx_next[0] = AW'(n_m1);
                        state_next  = crpf_pkg::ST_POS;
                    end else begin
                        idx_next[0] = (seg_reg == '0) ? '0 : AW'(seg_reg - 1'b1);
                        idx_next[1] = AW'(seg_reg);
                        idx_next[2] = AW'(seg_reg + 1'b1);
                        idx_next[3] = (seg_reg == n_m2) ? AW'(n_m1) : AW'(seg_reg + CW'(2));
                        state_next  = crpf_pkg::ST_DIVU;
                    end
                end else begin
                    if (seg_reg > n_m1) begin
                        seg_next = '0;
                    end
                    idx_next[0] = AW'(w0);
                    idx_next[1] = AW'(s0);
                    idx_next[2] = AW'(w2);
                    idx_next[3] = AW'(w3);
                    state_next  = crpf_pkg::ST_DIVU;
                end
            end
            crpf_pkg::ST_DIVU: begin
                if (!sent_reg) begin
                    div_start = 1'b1;
                    sent_next = 1'b1;
                end else if (div_stat.done) begin
                    sent_next  = 1'b0;
                    u_next     = div_q[crpf_pkg::U_W-1:0];
                    state_next = crpf_pkg::ST_READ;
                end
            end
            crpf_pkg::ST_READ: begin
                ram_raddr   = idx_reg[rd_cnt_reg[1:0]];
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (rd_cnt_reg != '0) begin
                    pt_next[2'(rd_cnt_reg - 3'd1)] = ram_rdata;
                end
                if (rd_cnt_reg == 3'd4) begin
                    rd_cnt_next = '0;
                    state_next  = crpf_pkg::ST_CUBIC;
                end
            end
            crpf_pkg::ST_CUBIC: begin
                if (!sent_reg) begin
                    cub_start = 1'b1;
                    sent_next = 1'b1;
                end else if (cub_stat.done) begin
                    sent_next    = 1'b0;
                    cur_pos_next = cub_pos;
                    state_next   = crpf_pkg::ST_EMIT;
                end
            end
            crpf_pkg::ST_POS: begin
                ram_raddr = idx_reg[0];
                if (rd_cnt_reg == '0) begin
                    rd_cnt_next = 3'd1;
                end else begin
                    rd_cnt_next  = '0;
                    cur_pos_next = ram_rdata;
                    if (end_reg) begin
                        prog_next  = crpf_pkg::PROG_ONE;
                        state_next = crpf_pkg::ST_EMIT;
                    end else begin
                        state_next = crpf_pkg::ST_DIVP;
                    end
                end
            end
            crpf_pkg::ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {5'b0, loop_err, active_reg, prog_reg, cur_pos_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = crpf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = crpf_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= crpf_pkg::ST_IDLE;
            seg_reg      <= '0;
            el_reg       <= '0;
            active_reg   <= 1'b0;
            cur_pos_reg  <= '0;
            end_reg      <= 1'b0;
            run_reg      <= 1'b0;
            sent_reg     <= 1'b0;
            rd_cnt_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            pc_reg       <= CW'(2);
            loop_reg     <= 1'b0;
            ticks_reg    <= TW'(60);
        end else begin
            state_reg    <= state_next;
            seg_reg      <= seg_next;
            el_reg       <= el_next;
            active_reg   <= active_next;
            cur_pos_reg  <= cur_pos_next;
            end_reg      <= end_next;
            run_reg      <= run_next;
            sent_reg     <= sent_next;
            rd_cnt_reg   <= rd_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    crpf_pkg::REG_POINT_COUNT:   pc_reg    <= cfg_wdata[CW-1:0];
                    crpf_pkg::REG_LOOP_MODE:     loop_reg  <= cfg_wdata[0];
                    crpf_pkg::REG_SEGMENT_TICKS: ticks_reg <= cfg_wdata[TW-1:0];
                    default: begin
                        pc_reg <= pc_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        prog_reg    <= prog_next;
        u_reg       <= u_next;
        idx_reg     <= idx_next;
        pt_reg      <= pt_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    crpf_ram #(
        .WIDTH (PW),
        .DEPTH (crpf_pkg::MAX_POINTS)
    ) u_point_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(s_tdata[5:0])),
        .wdata (s_tdata[101:6]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    crpf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_q)
    );

    crpf_cubic u_cubic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cub_start),
        .pts     (pt_reg),
        .u       (u_reg),
        .stat    (cub_stat),
        .pos     (cub_pos)
    );

    // A result leaves the sequencer only into a free output register
    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == crpf_pkg::ST_EMIT && (!m_tvalid_reg || m_tready)) |=> m_tvalid_reg)
        else $error("result not loaded into output register");

    // Progress never exceeds one
    a_prog_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[112:96] <= crpf_pkg::PROG_ONE))
        else $error("progress above one");

    // The divider is never restarted while it runs
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // Point writes happen only while the sequencer waits
    a_ram_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == crpf_pkg::ST_IDLE))
        else $error("point write outside idle");

    // The cubic unit is started only with four fresh points
    a_cub_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cub_start |-> ($past(state_reg) == crpf_pkg::ST_READ))
        else $error("cubic started without point reads");

endmodule

// ===== tb/catmull_rom_path_follower_tb.sv =====
// Self-checking testbench of the Catmull-Rom path follower: queued stimulus and a built-in predictor.
`timescale 1ns / 1ps

module catmull_rom_path_follower_tb;

    localparam int RUN_LIMIT = 3000000;
    localparam int SETTLE    = 200;
    localparam int NPHASE    = 12;

    typedef struct {
        crpf_pkg::cmd_t    cmd;
        logic [5:0]        slot;
        logic signed [31:0] px, py, pz;
    } path_cmd_t;

    typedef struct {
        logic [31:0] px, py, pz;
        logic [16:0] prog;
        logic        moving;
        logic        cfg_err;
    } path_pos_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [crpf_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [crpf_pkg::S_TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [crpf_pkg::M_TDATA_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [crpf_pkg::CFG_AW-1:0] cfg_addr = '0;
    logic [crpf_pkg::CFG_DW-1:0] cfg_wdata = '0;

    catmull_rom_path_follower dut (.*);

    always #5 aclk = ~aclk;

    // Predictor state
    logic signed [31:0] pts [crpf_pkg::MAX_POINTS][3];
    int unsigned seg_idx, elapsed, cnt_reg, loop_reg, ticks_reg;
    bit          is_active;
    logic signed [31:0] cur_pos [3];

    path_cmd_t cmd_queue[$];
    path_pos_t pos_queue[$];
    path_cmd_t on_bus;
    bit        s_took = 1'b0;
    int        send_idle = 0, recv_idle = 0;
    int        hold_left = 0;
    int        errors = 0;
    int        cycles = 0;

    function automatic int unsigned count_n();
        return cnt_reg < 2 ? 2 :
               (cnt_reg > crpf_pkg::MAX_POINTS ? crpf_pkg::MAX_POINTS : cnt_reg);
    endfunction

    function automatic bit loop_short();
        return loop_reg != 0 && count_n() < 3;
    endfunction

    function automatic int unsigned ticks_t();
        return ticks_reg == 0 ? 1 : ticks_reg;
    endfunction

    function automatic longint unsigned path_progress();
        longint unsigned segs, tt, p;
        segs = loop_reg != 0 ? count_n() : count_n() - 1;
        tt = ticks_t();
        p = ((longint'(seg_idx) * tt + elapsed) * 65536) / (segs * tt);
        return p > 65536 ? 65536 : p;
    endfunction

    function automatic logic signed [31:0] spline_axis(longint p0, longint p1, longint p2,
                                                      longint p3, longint u);
        longint t2, t3, a, b, c, d, s, h;
        t2 = (u * u) >> 16;
        t3 = (t2 * u) >> 16;
        a = 2 * p1;
        b = p2 - p0;
        c = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        d = -p0 + 3 * p1 - 3 * p2 + p3;
        s = a + ((b * u) >>> 16) + ((c * t2) >>> 16) + ((d * t3) >>> 16);
        h = s >>> 1;
        if (h > 64'sd2147483647) h = 64'sd2147483647;
        if (h < -64'sd2147483648) h = -64'sd2147483648;
        return h[31:0];
    endfunction

    function automatic path_pos_t held_pos(longint unsigned prog);
        path_pos_t r;
        r.px = cur_pos[0];
        r.py = cur_pos[1];
        r.pz = cur_pos[2];
        r.prog = prog[16:0];
        r.moving = is_active;
        r.cfg_err = loop_short();
        return r;
    endfunction

    // Advance the predictor by one accepted command and queue its result, if it gives one
    task automatic follow_cmd(path_cmd_t c);
        int unsigned n, tt, i0, i1, i2, i3;
        longint u;
        longint unsigned prog;
        n = count_n();
        tt = ticks_t();
        case (c.cmd)
            crpf_pkg::CMD_LOAD: begin
                pts[c.slot][0] = c.px;
                pts[c.slot][1] = c.py;
                pts[c.slot][2] = c.pz;
            end
            crpf_pkg::CMD_START: begin
                if (!loop_short()) begin
                    seg_idx = 0;
                    elapsed = 0;
                    is_active = 1'b1;
                    for (int k = 0; k < 3; k++) cur_pos[k] = pts[0][k];
                end
                pos_queue.insert(pos_queue.size(), held_pos(path_progress()));
            end
            crpf_pkg::CMD_TICK: begin
                if (!is_active) begin
                    pos_queue.insert(pos_queue.size(), held_pos(path_progress()));
                end else if (loop_short()) begin
                    is_active = 1'b0;
                    pos_queue.insert(pos_queue.size(), held_pos(path_progress()));
                end else begin
                    elapsed = (elapsed + 1) & 16'hFFFF;
                    if (elapsed >= tt) begin
                        elapsed = 0;
                        seg_idx++;
                    end
                    u = (longint'(elapsed) * 65536) / tt;
                    prog = path_progress();
                    if (loop_reg == 0 && seg_idx > n - 2) begin
                        // open path ran off its end: park on the last point
                        for (int k = 0; k < 3; k++) cur_pos[k] = pts[n - 1][k];
                        is_active = 1'b0;
                        pos_queue.insert(pos_queue.size(), held_pos(65536));
                    end else begin
                        if (loop_reg == 0) begin
                            i0 = seg_idx == 0 ? 0 : seg_idx - 1;
                            i1 = seg_idx;
                            i2 = seg_idx + 1;
                            i3 = seg_idx == n - 2 ? n - 1 : seg_idx + 2;
                        end else begin
                            if (seg_idx > n - 1) seg_idx = 0;
                            i0 = (seg_idx + n - 1) % n;
                            i1 = seg_idx;
                            i2 = (seg_idx + 1) % n;
                            i3 = (seg_idx + 2) % n;
                        end
                        for (int k = 0; k < 3; k++)
                            cur_pos[k] = spline_axis(pts[i0][k], pts[i1][k], pts[i2][k],
                                                     pts[i3][k], u);
                        pos_queue.insert(pos_queue.size(), held_pos(prog));
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] rand_coord();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
        return $signed($urandom) >>> $urandom_range(24);
    endfunction

    function automatic path_cmd_t make_cmd(crpf_pkg::cmd_t op, int slot);
        path_cmd_t c;
        c.cmd = op;
        c.slot = slot[5:0];
        c.px = rand_coord();
        c.py = rand_coord();
        c.pz = rand_coord();
        return c;
    endfunction

    function automatic path_cmd_t rand_cmd();
        int r;
        r = $urandom_range(99);
        if (r < 8)  return make_cmd(crpf_pkg::CMD_START, $urandom_range(63));
        if (r < 20) return make_cmd(crpf_pkg::CMD_LOAD, $urandom_range(63));
        if (r < 23) return make_cmd(crpf_pkg::CMD_NOP, $urandom_range(63));
        return make_cmd(crpf_pkg::CMD_TICK, $urandom_range(63));
    endfunction

    // Sender: present the next queued command, idle at random
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || s_took)) begin
            if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
                on_bus = cmd_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {2'b00, on_bus.pz, on_bus.py, on_bus.px, on_bus.slot};
                s_tuser <= on_bus.cmd;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random, or hold off for a long stretch
    always @(negedge aclk) begin
        m_tready <= hold_left == 0 && $urandom_range(99) >= recv_idle;
    end

    always @(negedge aclk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // Input monitor: predict on every accepted transfer
    always @(posedge aclk) begin
        s_took <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) follow_cmd(on_bus);
    end

    // Output monitor: compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        path_pos_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.px = m_tdata[31:0];
            got.py = m_tdata[63:32];
            got.pz = m_tdata[95:64];
            got.prog = m_tdata[112:96];
            got.moving = m_tdata[113];
            got.cfg_err = m_tdata[114];
            if (pos_queue.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
            end else begin
                want = pos_queue.pop_front();
                if (got.px !== want.px || got.py !== want.py || got.pz !== want.pz ||
                    got.prog !== want.prog || got.moving !== want.moving ||
                    got.cfg_err !== want.cfg_err) begin
                    errors++;
                    if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic wait_idle();
        wait (cmd_queue.size() == 0 && !s_tvalid && pos_queue.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [crpf_pkg::CFG_AW-1:0] idx, int unsigned val);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val[crpf_pkg::CFG_DW-1:0];
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            crpf_pkg::REG_POINT_COUNT:   cnt_reg = val & 7'h7F;
            crpf_pkg::REG_LOOP_MODE:     loop_reg = val & 1;
            crpf_pkg::REG_SEGMENT_TICKS: ticks_reg = val & 16'hFFFF;
            default: ;
        endcase
    endtask

    task automatic set_path(int unsigned n, int unsigned lp, int unsigned tk);
        write_reg(crpf_pkg::REG_POINT_COUNT, n);
        write_reg(crpf_pkg::REG_LOOP_MODE, lp);
        write_reg(crpf_pkg::REG_SEGMENT_TICKS, tk);
    endtask

    task automatic push_ops(crpf_pkg::cmd_t op, int reps);
        repeat (reps) cmd_queue.insert(cmd_queue.size(), make_cmd(op, 0));
    endtask

    int unsigned ph_cnt  [NPHASE] = '{2, 64, 5, 3, 2, 1, 0, 100, 8, 64, 4, 6};
    int unsigned ph_loop [NPHASE] = '{0, 0, 1, 1, 1, 1, 0, 0, 1, 1, 0, 1};
    int unsigned ph_ticks[NPHASE] = '{1, 3, 4, 1, 5, 2, 0, 65535, 2, 1, 3, 7};

    initial begin
        path_cmd_t c;
        seg_idx = 0; elapsed = 0; is_active = 1'b0;
        cnt_reg = 2; loop_reg = 0; ticks_reg = 60;
        for (int k = 0; k < 3; k++) cur_pos[k] = '0;
        send_idle = 24;
        recv_idle = 71;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Fill every point slot, extremes in the first ones
        for (int i = 0; i < crpf_pkg::MAX_POINTS; i++) begin
            c = make_cmd(crpf_pkg::CMD_LOAD, i);
            if (i == 1) begin c.px = 32'sh7FFFFFFF; c.py = 32'sh80000000; c.pz = 0; end
            if (i == 2) begin c.px = 32'sh80000000; c.py = 32'sh7FFFFFFF; c.pz = -1; end
            cmd_queue.insert(cmd_queue.size(), c);
        end
        // Defaults from reset: tick while inactive, then a short open path
        push_ops(crpf_pkg::CMD_TICK, 1);
        push_ops(crpf_pkg::CMD_START, 1);
        push_ops(crpf_pkg::CMD_TICK, 2);
        wait_idle();
        set_path(3, 0, 2);
        push_ops(crpf_pkg::CMD_START, 1);
        push_ops(crpf_pkg::CMD_TICK, 6);
        push_ops(crpf_pkg::CMD_NOP, 1);
        wait_idle();
        // Loop wrap, then shrink the loop below three points while moving
        set_path(3, 1, 1);
        push_ops(crpf_pkg::CMD_START, 1);
        push_ops(crpf_pkg::CMD_TICK, 5);
        wait_idle();
        write_reg(crpf_pkg::REG_POINT_COUNT, 2);
        push_ops(crpf_pkg::CMD_TICK, 2);
        push_ops(crpf_pkg::CMD_START, 1);
        wait_idle();

        for (int p = 0; p < NPHASE; p++) begin
            send_idle = p < 4 ? 24 : (p < 8 ? 71 : 0);
            recv_idle = p < 4 ? 71 : (p < 8 ? 24 : 0);
            set_path(ph_cnt[p], ph_loop[p], ph_ticks[p]);
            push_ops(crpf_pkg::CMD_START, 1);
            repeat (150) cmd_queue.insert(cmd_queue.size(), rand_cmd());
            // Long receiver stall while the sender keeps offering
            if (p == 1 || p == 9) begin
                @(posedge aclk);
                hold_left = 3000;
            end
            wait_idle();
        end

        if (pos_queue.size() != 0) errors++;
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== catmull_rom_path_follower.f =====
hdl/crpf_pkg.sv
hdl/crpf_ram.sv
hdl/crpf_div.sv
hdl/crpf_cubic.sv
hdl/catmull_rom_path_follower.sv
tb/catmull_rom_path_follower_tb.sv
